[hw/rtl/mcr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mcr_pkg;

    localparam int unsigned COORD_W = 12;
    localparam int unsigned STEP_W  = 13;
    localparam int unsigned POS_W   = 14;
    localparam int unsigned DEC_W   = 16;
    localparam int unsigned IDX_W   = 4;

    // Order of the words produced by one advance: four fill spans, then eight pixels.
    localparam logic [IDX_W-1:0] IDX_FIRST_SPAN  = 4'd0;
    localparam logic [IDX_W-1:0] IDX_FIRST_PIXEL = 4'd4;
    localparam logic [IDX_W-1:0] IDX_LAST        = 4'd11;

    typedef enum logic [1:0] {
        KIND_PIXEL = 2'd0,
        KIND_SPAN  = 2'd1,
        KIND_IDLE  = 2'd2
    } kind_t;

    typedef enum logic {
        MODE_LOAD    = 1'b0,
        MODE_ADVANCE = 1'b1
    } mode_t;

    // One iteration handed from the circle state to the word generator.
    typedef struct packed {
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [STEP_W-1:0]  x;
        logic [STEP_W-1:0]  y;
        logic               fill;
        logic               idle;
        logic               done;
    } job_t;

endpackage

`default_nettype wire

[hw/rtl/mcr_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface mcr_in_if;
    import mcr_pkg::*;

    logic               valid;
    logic               ready;
    logic               mode;
    logic [COORD_W-1:0] center_x;
    logic [COORD_W-1:0] center_y;
    logic [COORD_W-1:0] radius;

    modport source (output valid, mode, center_x, center_y, radius, input ready);
    modport sink   (input valid, mode, center_x, center_y, radius, output ready);
endinterface

interface mcr_out_if;
    import mcr_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [1:0]              kind;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] span_end_x;
    logic                    last;
    logic                    done_res;

    modport source (output valid, kind, pos_x, pos_y, span_end_x, last, done_res,
                    input ready);
    modport sink   (input valid, kind, pos_x, pos_y, span_end_x, last, done_res,
                    output ready);
endinterface

`default_nettype wire

[hw/rtl/mcr_emit.sv]
`timescale 1ns / 1ps
`default_nettype none

module mcr_emit (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire mcr_pkg::job_t job,
    output logic               take,
    mcr_out_if.source          res
);
    import mcr_pkg::*;

    logic                    busy_reg;
    logic [IDX_W-1:0]        idx_reg;
    job_t                    job_reg;
    logic                    out_valid_reg;
    kind_t                   kind_reg;
    logic [POS_W-1:0]        pos_x_reg;
    logic [POS_W-1:0]        pos_y_reg;
    logic [POS_W-1:0]        end_x_reg;
    logic                    last_reg;
    logic                    done_reg;

    logic                    emit;
    logic                    is_last;
    kind_t                   kind_next;
    logic [POS_W-1:0]        pos_x_next;
    logic [POS_W-1:0]        pos_y_next;
    logic [POS_W-1:0]        end_x_next;
    logic [POS_W-1:0]        cx;
    logic [POS_W-1:0]        cy;
    logic [POS_W-1:0]        sx;
    logic [POS_W-1:0]        sy;

    // All coordinate sums wrap at the width of the result fields.
    assign cx = {{(POS_W-COORD_W){1'b0}}, job_reg.cx};
    assign cy = {{(POS_W-COORD_W){1'b0}}, job_reg.cy};
    assign sx = {{(POS_W-STEP_W){1'b0}}, job_reg.x};
    assign sy = {{(POS_W-STEP_W){1'b0}}, job_reg.y};

    assign emit    = busy_reg && (!out_valid_reg || res.ready);
    assign is_last = job_reg.idle || (idx_reg == IDX_LAST);
    assign take    = !busy_reg || (emit && is_last);

    always_comb
    begin
        kind_next  = KIND_PIXEL;
        pos_x_next = '0;
        pos_y_next = '0;
        end_x_next = '0;
        if (job_reg.idle)
        begin
            kind_next = KIND_IDLE;
        end
        else
        begin
            case (idx_reg)
                4'd0:
                begin
                    kind_next  = KIND_SPAN;
                    pos_x_next = cx - sx;
                    pos_y_next = cy + sy - 1'b1;
                    end_x_next = cx + sx + 1'b1;
                end
                4'd1:
                begin
                    kind_next  = KIND_SPAN;
                    pos_x_next = cx - sy + 1'b1;
                    pos_y_next = cy + sx;
                    end_x_next = cx + sy;
                end
                4'd2:
                begin
                    kind_next  = KIND_SPAN;
                    pos_x_next = cx - sy + 1'b1;
                    pos_y_next = cy - sx;
                    end_x_next = cx + sy;
                end
                4'd3:
                begin
                    kind_next  = KIND_SPAN;
                    pos_x_next = cx - sx;
                    pos_y_next = cy - sy + 1'b1;
                    end_x_next = cx + sx + 1'b1;
                end
                4'd4:
                begin
                    pos_x_next = cx + sx;
                    pos_y_next = cy + sy;
                end
                4'd5:
                begin
                    pos_x_next = cx - sx;
                    pos_y_next = cy + sy;
                end
                4'd6:
                begin
                    pos_x_next = cx + sx;
                    pos_y_next = cy - sy;
                end
                4'd7:
                begin
                    pos_x_next = cx - sx;
                    pos_y_next = cy - sy;
                end
                4'd8:
                begin
                    pos_x_next = cx + sy;
                    pos_y_next = cy + sx;
                end
                4'd9:
                begin
                    pos_x_next = cx - sy;
                    pos_y_next = cy + sx;
                end
                4'd10:
                begin
                    pos_x_next = cx + sy;
                    pos_y_next = cy - sx;
                end
                4'd11:
                begin
                    pos_x_next = cx - sy;
                    pos_y_next = cy - sx;
                end
                default:
                begin
                    kind_next = KIND_PIXEL;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= IDX_FIRST_SPAN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (start)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= job.fill ? IDX_FIRST_SPAN : IDX_FIRST_PIXEL;
            end
            else if (emit && is_last)
            begin
                busy_reg <= 1'b0;
            end
            else if (emit)
            begin
                idx_reg <= idx_reg + 1'b1;
            end

            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            job_reg <= job;
        end
        if (emit)
        begin
            kind_reg  <= kind_next;
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
            end_x_reg <= end_x_next;
            last_reg  <= is_last;
            done_reg  <= is_last && (job_reg.idle || job_reg.done);
        end
    end

    assign res.valid      = out_valid_reg;
    assign res.kind       = kind_reg;
    assign res.pos_x      = pos_x_reg;
    assign res.pos_y      = pos_y_reg;
    assign res.span_end_x = end_x_reg;
    assign res.last       = last_reg;
    assign res.done_res   = done_reg;

endmodule

`default_nettype wire

[hw/rtl/midpoint_circle_rasterizer_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Midpoint circle rasterizer. A load word (mode 0) sets the centre and radius of a
// new circle and gives no result; it restarts any circle in progress.
// Each advance word (mode 1) runs one iteration of the midpoint loop and gives
// twelve result words with fill enabled (four fill spans, then eight outline
// pixels), eight without, or a single idle word once the circle has finished or before the first load.
// The result channel moves one word per cycle while res.ready is high; an advance
// holds the word generator until the next command word is taken, in the cycle the
// last result of the current one enters the output register. The fill setting is
// sampled when an advance is accepted and should be written while idle.
module midpoint_circle_rasterizer_core (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_write,
    input  wire logic cfg_wdata,
    mcr_in_if.sink    cmd,
    mcr_out_if.source res
);
    import mcr_pkg::*;

    logic               fill_reg;
    logic [COORD_W-1:0] ctr_x_reg;
    logic [COORD_W-1:0] ctr_y_reg;
    logic [STEP_W-1:0]  step_x_reg;
    logic [STEP_W-1:0]  step_y_reg;
    logic [DEC_W-1:0]   decision_reg;
    logic               active_reg;

    logic               take;
    logic               accept;
    logic               is_load;
    logic               start;
    job_t               job;
    logic [DEC_W-1:0]   two_x;
    logic [DEC_W-1:0]   two_y;
    logic [DEC_W-1:0]   decision_next;
    logic [POS_W-1:0]   x_next;
    logic [POS_W-1:0]   y_next;
    logic               finished;

    assign accept    = cmd.valid && cmd.ready;
    assign is_load   = (mode_t'(cmd.mode) == MODE_LOAD);
    assign start     = accept && !is_load;
    assign cmd.ready = take;

    assign two_x = {{(DEC_W-STEP_W-1){1'b0}}, step_x_reg, 1'b0};
    assign two_y = {{(DEC_W-STEP_W-1){1'b0}}, step_y_reg, 1'b0};

    // Decision term wraps at sixteen bits; old x and y feed the sum.
    always_comb
    begin
        if (decision_reg[DEC_W-1])
        begin
            decision_next = decision_reg + two_x + DEC_W'(3);
            y_next        = {1'b0, step_y_reg};
        end
        else
        begin
            decision_next = decision_reg + two_x - two_y + DEC_W'(5);
            y_next        = {1'b0, step_y_reg} - 1'b1;
        end
        x_next   = {1'b0, step_x_reg} + 1'b1;
        finished = $signed(x_next) > $signed(y_next);
    end

    always_comb
    begin
        job.cx   = ctr_x_reg;
        job.cy   = ctr_y_reg;
        job.x    = step_x_reg;
        job.y    = step_y_reg;
        job.fill = fill_reg;
        job.idle = !active_reg;
        job.done = finished;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= 1'b0;
            ctr_x_reg    <= '0;
            ctr_y_reg    <= '0;
            step_x_reg   <= '0;
            step_y_reg   <= '0;
            decision_reg <= '0;
            active_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                fill_reg <= cfg_wdata;
            end

            if (accept && is_load)
            begin
                ctr_x_reg    <= cmd.center_x;
                ctr_y_reg    <= cmd.center_y;
                step_x_reg   <= '0;
                step_y_reg   <= {1'b0, cmd.radius};
                decision_reg <= DEC_W'(1) - {{(DEC_W-COORD_W){1'b0}}, cmd.radius};
                active_reg   <= 1'b1;
            end
            else if (start && active_reg)
            begin
                step_x_reg   <= x_next[STEP_W-1:0];
                step_y_reg   <= y_next[STEP_W-1:0];
                decision_reg <= decision_next;
                active_reg   <= !finished;
            end
        end
    end

    mcr_emit u_emit (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .job   (job),
        .take  (take),
        .res   (res)
    );

endmodule

`default_nettype wire
